// File: hw/rtl/train_speed_packet_builder_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file of the speed packet builder.
// ----------------------------------------------------------------------------
`ifndef TRAIN_SPEED_PACKET_BUILDER_TOP_DEFINES_SVH
`define TRAIN_SPEED_PACKET_BUILDER_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define TSPB_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tspb check failed");

// Next-cycle implication, checked out of reset
`define TSPB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tspb check failed");

`endif

// File: hw/rtl/tspb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tspb_pkg
// Types and constants for the train speed packet builder.
// ----------------------------------------------------------------------------
package tspb_pkg;

  localparam int unsigned LVL_W = 15;
  localparam int unsigned SPD_W = 7;
  localparam int unsigned IDX_W = 4;
  localparam int unsigned DAT_W = 15;

  // DCC packet bytes and lengths
  localparam logic [7:0] ADV_COMMAND = 8'h3F;
  localparam logic [7:0] BASIC_FWD   = 8'h60;
  localparam logic [7:0] BASIC_REV   = 8'h40;
  localparam logic [2:0] LEN_ADV     = 3'd4;
  localparam logic [2:0] LEN_BASIC   = 3'd3;
  localparam logic [2:0] LEN_NONE    = 3'd0;

  // Configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_DCC_ENABLE    = 4'd0,
    REG_ADV_STEPS     = 4'd1,
    REG_LOCO_ADDR     = 4'd2,
    REG_DCC_LIMIT     = 4'd3,
    REG_ANALOG_LIMIT  = 4'd4,
    REG_JUMP_START    = 4'd5,
    REG_LIGHT_ON      = 4'd6,
    REG_LIGHT_BASE    = 4'd7
  } reg_idx_t;

  typedef struct packed {
    logic             dcc_enable;
    logic             advanced_steps;
    logic [7:0]       loco_address;
    logic [SPD_W-1:0] dig_speed_limit;
    logic [LVL_W-1:0] analog_speed_limit;
    logic [LVL_W-1:0] jump_start_level;
    logic             lamp_en;
    logic [LVL_W-1:0] light_base_level;
  } cfg_t;

  typedef struct packed {
    logic [LVL_W-1:0] applied_level;
    logic             rejected;
    logic [LVL_W-1:0] forward_compare;
    logic [LVL_W-1:0] reverse_compare;
    logic [7:0]       pkt_address;
    logic [7:0]       pkt_first;
    logic [7:0]       pkt_second;
    logic [7:0]       pkt_check;
    logic [2:0]       pkt_length;
  } result_t;

endpackage

// File: hw/rtl/train_speed_packet_builder_top.sv
// An input beat reaches the result beat through the input register, then the result register.
// Throughput: one beat per cycle while out_stall is low; the step logic between the two registers is one pass.
// out_stall backs up through the input register to in_stall in the same cycle.
// Reset (rst_n low, synchronous): pipeline empty, registers at defaults, speed state zero.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// train_speed_packet_builder_top
// Speed controller: DCC speed packets or analog PWM compare values per tick.
// ----------------------------------------------------------------------------
module train_speed_packet_builder_top (
  input  logic                               clk,
  input  logic                               rst_n,
  // Input channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [7:0]                  in_speed_delta,
  input  logic                               in_direction,
  // Result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [tspb_pkg::LVL_W-1:0]         out_applied_level,
  output logic                               out_rejected,
  output logic [tspb_pkg::LVL_W-1:0]         out_forward_compare,
  output logic [tspb_pkg::LVL_W-1:0]         out_reverse_compare,
  output logic [7:0]                         out_pkt_address,
  output logic [7:0]                         out_pkt_first,
  output logic [7:0]                         out_pkt_second,
  output logic [7:0]                         out_pkt_check,
  output logic [2:0]                         out_pkt_length,
  // Configuration write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tspb_pkg::IDX_W-1:0]         cfg_index,
  input  logic [tspb_pkg::DAT_W-1:0]         cfg_data
);
  import tspb_pkg::*;

  cfg_t              cfg;
  result_t           step_res;
  result_t           res_r;
  logic              s1_valid_r, s1_valid_nxt;
  logic signed [7:0] s1_delta_r;
  logic              s1_dir_r;
  logic              out_valid_r, out_valid_nxt;
  logic              out_free;
  logic              s1_go;
  logic              in_acc;

  tspb_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tspb_step u_step (
    .clk         (clk),
    .rst_n       (rst_n),
    .advance     (s1_go),
    .cfg         (cfg),
    .speed_delta (s1_delta_r),
    .direction   (s1_dir_r),
    .res         (step_res)
  );

  // Flow control between input register and result register
  assign out_free      = !out_valid_r || !out_stall;
  assign s1_go         = s1_valid_r && out_free;
  assign in_stall      = s1_valid_r && !out_free;
  assign in_acc        = in_valid && !in_stall;
  assign s1_valid_nxt  = in_acc || (s1_valid_r && !s1_go);
  assign out_valid_nxt = s1_go || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_delta_r <= in_speed_delta;
      s1_dir_r   <= in_direction;
    end
    if (s1_go) begin
      res_r <= step_res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_applied_level   = res_r.applied_level;
  assign out_rejected        = res_r.rejected;
  assign out_forward_compare = res_r.forward_compare;
  assign out_reverse_compare = res_r.reverse_compare;
  assign out_pkt_address     = res_r.pkt_address;
  assign out_pkt_first       = res_r.pkt_first;
  assign out_pkt_second      = res_r.pkt_second;
  assign out_pkt_check       = res_r.pkt_check;
  assign out_pkt_length      = res_r.pkt_length;

endmodule

// File: hw/rtl/tspb_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tspb_cfg
// Configuration register file; one write beat per cycle, never stalls.
// ----------------------------------------------------------------------------
module tspb_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [tspb_pkg::IDX_W-1:0]  cfg_index,
  input  logic [tspb_pkg::DAT_W-1:0]  cfg_data,
  output tspb_pkg::cfg_t              cfg
);
  import tspb_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  // Decode write beat; unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_DCC_ENABLE:   cfg_nxt.dcc_enable         = cfg_data[0];
        REG_ADV_STEPS:    cfg_nxt.advanced_steps     = cfg_data[0];
        REG_LOCO_ADDR:    cfg_nxt.loco_address       = cfg_data[7:0];
        REG_DCC_LIMIT:    cfg_nxt.dig_speed_limit    = cfg_data[SPD_W-1:0];
        REG_ANALOG_LIMIT: cfg_nxt.analog_speed_limit = cfg_data[LVL_W-1:0];
        REG_JUMP_START:   cfg_nxt.jump_start_level   = cfg_data[LVL_W-1:0];
        REG_LIGHT_ON:     cfg_nxt.lamp_en            = cfg_data[0];
        REG_LIGHT_BASE:   cfg_nxt.light_base_level   = cfg_data[LVL_W-1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dcc_enable         <= 1'b1;
      cfg_r.advanced_steps     <= 1'b1;
      cfg_r.loco_address       <= 8'd3;
      cfg_r.dig_speed_limit    <= {SPD_W{1'b1}};
      cfg_r.analog_speed_limit <= {LVL_W{1'b1}};
      cfg_r.jump_start_level   <= '0;
      cfg_r.lamp_en            <= 1'b1;
      cfg_r.light_base_level   <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// File: hw/rtl/tspb_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tspb_step
// Speed state and one-pass step logic: clamp, reversal guard, packet or PWM.
// ----------------------------------------------------------------------------
module tspb_step (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              advance,
  input  tspb_pkg::cfg_t    cfg,
  input  logic signed [7:0] speed_delta,
  input  logic              direction,
  output tspb_pkg::result_t res
);
  import tspb_pkg::*;

  logic                     last_dir_r, last_dir_nxt;
  logic [SPD_W-1:0]         dspeed_r, dspeed_nxt;
  logic [LVL_W-1:0]         fwd_lvl_r, fwd_lvl_nxt;
  logic [LVL_W-1:0]         rev_lvl_r, rev_lvl_nxt;

  logic signed [8:0]        dsum;
  logic [SPD_W-1:0]         dclamp;
  logic [LVL_W-1:0]         base;
  logic [LVL_W-1:0]         cur_raw;
  logic [LVL_W-1:0]         cur;
  logic signed [16:0]       asum;
  logic signed [16:0]       aval;
  logic [LVL_W-1:0]         alevel;
  logic [7:0]               first;
  logic [7:0]               second;

  // Digital speed: add step, clamp to zero and limit
  always_comb begin
    dsum = $signed({2'b00, dspeed_r}) + 9'(speed_delta);
    if (dsum < 0) begin
      dclamp = '0;
    end else if (dsum > $signed({2'b00, cfg.dig_speed_limit})) begin
      dclamp = cfg.dig_speed_limit;
    end else begin
      dclamp = dsum[SPD_W-1:0];
    end
  end

  // Analog level: floor, jump start, then limit
  always_comb begin
    base    = cfg.lamp_en ? cfg.light_base_level : '0;
    cur_raw = direction ? fwd_lvl_r : rev_lvl_r;
    cur     = (cur_raw < base) ? base : cur_raw;
    asum    = $signed({2'b00, cur}) + 17'(speed_delta);
    if (cur == base) begin
      if (speed_delta < 0) begin
        aval = $signed({2'b00, base});
      end else if (asum < $signed({2'b00, cfg.jump_start_level})) begin
        aval = $signed({2'b00, cfg.jump_start_level});
      end else begin
        aval = asum;
      end
    end else if (asum < $signed({2'b00, base})) begin
      aval = $signed({2'b00, base});
    end else begin
      aval = asum;
    end
    if (aval > $signed({2'b00, cfg.analog_speed_limit})) begin
      alevel = cfg.analog_speed_limit;
    end else begin
      alevel = aval[LVL_W-1:0];
    end
  end

  // Reversal guard, packet build and next state
  always_comb begin
    last_dir_nxt = last_dir_r;
    dspeed_nxt   = dspeed_r;
    fwd_lvl_nxt  = fwd_lvl_r;
    rev_lvl_nxt  = rev_lvl_r;
    res          = '0;
    first        = '0;
    second       = '0;
    if (cfg.dcc_enable) begin
      dspeed_nxt = dclamp;
      if (last_dir_r != direction) begin
        if (dclamp == '0) begin
          last_dir_nxt = direction;
        end else begin
          dspeed_nxt   = '0;
          res.rejected = 1'b1;
        end
      end
      if (cfg.advanced_steps) begin
        first          = ADV_COMMAND;
        second         = {direction, dspeed_nxt};
        res.pkt_length = LEN_ADV;
      end else begin
        first          = (direction ? BASIC_FWD : BASIC_REV)
                         | {3'b000, dspeed_nxt[SPD_W-1:2]};
        second         = '0;
        res.pkt_length = LEN_BASIC;
      end
      res.pkt_address   = cfg.loco_address;
      res.pkt_first     = first;
      res.pkt_second    = second;
      res.pkt_check     = cfg.loco_address ^ first ^ second;
      res.applied_level = {{(LVL_W-SPD_W){1'b0}}, dspeed_nxt};
    end else begin
      res.applied_level = alevel;
      if (last_dir_r != direction) begin
        if (alevel == base) begin
          last_dir_nxt = direction;
        end else begin
          res.applied_level = base;
          res.rejected      = 1'b1;
        end
      end
      fwd_lvl_nxt         = direction ? res.applied_level : '0;
      rev_lvl_nxt         = direction ? '0 : res.applied_level;
      res.forward_compare = fwd_lvl_nxt;
      res.reverse_compare = rev_lvl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_dir_r <= 1'b1;
      dspeed_r   <= '0;
      fwd_lvl_r  <= '0;
      rev_lvl_r  <= '0;
    end else if (advance) begin
      last_dir_r <= last_dir_nxt;
      dspeed_r   <= dspeed_nxt;
      fwd_lvl_r  <= fwd_lvl_nxt;
      rev_lvl_r  <= rev_lvl_nxt;
    end
  end

endmodule

// File: hw/rtl/tspb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tspb_checker
// Port-level checks on the result channel of the speed packet builder.
// ----------------------------------------------------------------------------
`include "train_speed_packet_builder_top_defines.svh"

module tspb_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic [tspb_pkg::LVL_W-1:0] out_applied_level,
  input  logic                       out_rejected,
  input  logic [tspb_pkg::LVL_W-1:0] out_forward_compare,
  input  logic [tspb_pkg::LVL_W-1:0] out_reverse_compare,
  input  logic [7:0]                 out_pkt_address,
  input  logic [7:0]                 out_pkt_first,
  input  logic [7:0]                 out_pkt_second,
  input  logic [7:0]                 out_pkt_check,
  input  logic [2:0]                 out_pkt_length
);
  import tspb_pkg::*;

  // A stalled result beat stays offered
  `TSPB_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)

  // Packet check byte covers address and both data bytes
  `TSPB_ASSERT_NOW(a_pkt_check, clk, rst_n, out_valid && out_pkt_length != LEN_NONE,
    out_pkt_check == (out_pkt_address ^ out_pkt_first ^ out_pkt_second))

  // A refused reversal in digital mode sends speed zero and no PWM
  `TSPB_ASSERT_NOW(a_dcc_reject, clk, rst_n,
    out_valid && out_pkt_length != LEN_NONE,
    (!out_rejected || out_applied_level == '0) &&
    out_forward_compare == '0 && out_reverse_compare == '0)

  // Analog mode drives at most one direction
  `TSPB_ASSERT_NOW(a_one_side, clk, rst_n, out_valid && out_pkt_length == LEN_NONE,
    out_forward_compare == '0 || out_reverse_compare == '0)

endmodule

bind train_speed_packet_builder_top tspb_checker u_tspb_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_applied_level   (out_applied_level),
  .out_rejected        (out_rejected),
  .out_forward_compare (out_forward_compare),
  .out_reverse_compare (out_reverse_compare),
  .out_pkt_address     (out_pkt_address),
  .out_pkt_first       (out_pkt_first),
  .out_pkt_second      (out_pkt_second),
  .out_pkt_check       (out_pkt_check),
  .out_pkt_length      (out_pkt_length)
);
